### hw/rtl/cve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cve_pkg: shared types and constants of the cookie value extractor
// character codes, register indexes, result kinds and the command and status
// bundles between the controller and the datapath
// ----------------------------------------------------------------------------
package cve_pkg;

  localparam int KEY_BYTES = 16;
  localparam int HELD_DEPTH_DEFAULT = 32;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W = 5;
  localparam int KEY_LEN_W = 5;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_EQ = 8'h3D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_END = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SEL_REPLAY = 2'd0,
    SEL_BYTE = 2'd1,
    SEL_FINAL = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic header_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic [1:0] result_kind;
    logic pending_overflow;
    logic last_of_run;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic rep_step;
    logic emit;
    emit_sel_t sel;
    logic last;
  } cve_cmd_t;

  typedef struct packed {
    logic rep_more;
    logic byte_pend;
    logic end_pend;
    logic out_free;
  } cve_status_t;

endpackage

### hw/rtl/cookie_value_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cookie_value_extractor: streams out the value of one named cookie
// parses a cookie header byte by byte and returns the value of the first
// cookie whose name equals the configured key
// ----------------------------------------------------------------------------
// usage
//   - write key_bytes_low, key_bytes_high and key_length through the cfg port
//     while the block is idle; writes take effect at once, no read-back
//   - input words carry one header byte and a flag on the header's last byte
//   - each input word yields zero or more result words; the last one of the
//     group has last_of_run set
// timing
//   - an input word is taken, then the controller walks its results in order:
//     each replayed whitespace byte takes a ram read, then an emit, followed
//     by the value/end step and the header-end step
//   - the input is ready only while the controller is idle, so the
//     sequencer sets the rate
// reset and stall
//   - rst clears the key registers, the parser and the output register;
//     the held whitespace ram needs no clearing, only written entries are read
//   - the output register holds a word until it is taken; while the receiver
//     stalls the controller waits and no result is dropped
// ----------------------------------------------------------------------------
module cookie_value_extractor
  import cve_pkg::*;
#(
  parameter int HELD_DEPTH = HELD_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // header byte channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  // key configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // command and status between sequencer and datapath
  cve_cmd_t cmd;
  cve_status_t status;

  // controller: one word at a time, replay, value, then end result
  cve_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // datapath: key match, parser state, held whitespace ram, output register
  cve_dp #(
    .HELD_DEPTH(HELD_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

### hw/rtl/cve_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cve_ram: generic single-write, single-read ram
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module cve_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/cve_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cve_ctrl: sequencing controller of the cookie value extractor
// accepts one word, then walks the replay, value and end results in order
// ----------------------------------------------------------------------------
module cve_ctrl
  import cve_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cve_status_t status,
  output cve_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_REP_RD   = 5'b00010,
    ST_REP_EMIT = 5'b00100,
    ST_BYTE     = 5'b01000,
    ST_FINAL    = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '{accept: 1'b0, rep_step: 1'b0, emit: 1'b0, sel: SEL_BYTE, last: 1'b0};
    case (state)
      ST_IDLE: begin
        // no word is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = ST_REP_RD;
        end
      end
      ST_REP_RD: begin
        // read address settles here, data is ready next cycle
        state_next = status.rep_more ? ST_REP_EMIT : ST_BYTE;
      end
      ST_REP_EMIT: begin
        cmd.sel = SEL_REPLAY;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.rep_step = 1'b1;
          state_next = ST_REP_RD;
        end
      end
      ST_BYTE: begin
        cmd.sel = SEL_BYTE;
        cmd.last = !status.end_pend;
        if (!status.byte_pend) begin
          state_next = ST_FINAL;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.sel = SEL_FINAL;
        cmd.last = 1'b1;
        if (!status.end_pend) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/cve_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cve_dp: datapath of the cookie value extractor
// key registers, cookie parser state, held whitespace store and output register
// ----------------------------------------------------------------------------
module cve_dp
  import cve_pkg::*;
#(
  parameter int HELD_DEPTH = HELD_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_word_t             in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_word_t            out_data,
  input  cve_cmd_t             cmd,
  output cve_status_t          status
);

  localparam int CntW = $clog2(HELD_DEPTH + 1);
  localparam int AddrW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [5:0] {
    PH_SEP       = 6'b000001,
    PH_NAME      = 6'b000010,
    PH_SKIP      = 6'b000100,
    PH_VAL_MATCH = 6'b001000,
    PH_VAL_OTHER = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_t;

  // key registers
  logic [63:0] key_low, key_high;
  logic [KEY_LEN_W-1:0] key_len;

  // parser state
  phase_t phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic mis, mis_next;
  logic [CntW-1:0] held, held_next;
  logic ovf, ovf_next;

  // per-word work registers
  logic [7:0] byte_q;
  logic semi_q, semi_next;
  logic byte_pend, byte_pend_next;
  logic end_pend, end_pend_next;
  kind_t end_kind, end_kind_next;
  logic ovf_q;
  logic [CntW-1:0] rep_cnt, rep_cnt_next;
  logic [CntW-1:0] rep_idx;

  logic [127:0] key_all;
  logic [7:0] b, key_sel;
  logic is_ws, is_semi, is_eq;
  logic name_go;
  logic [POS_W-1:0] npos;
  logic nmis;
  logic ram_we;
  logic ram_rdata;
  out_word_t word;

  assign key_all = {key_high, key_low};
  assign b = in_data.header_byte;
  assign is_ws = (b == CHAR_SPACE) || (b == CHAR_TAB);
  assign is_semi = (b == CHAR_SEMI);
  assign is_eq = (b == CHAR_EQ);
  assign key_sel = key_all[{npos[3:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      key_len <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_LOW:  key_low <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LEN:  key_len <= cfg_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    pos_next = pos;
    mis_next = mis;
    held_next = held;
    ovf_next = ovf;
    rep_cnt_next = '0;
    byte_pend_next = 1'b0;
    semi_next = 1'b0;
    ram_we = 1'b0;
    name_go = 1'b0;
    npos = pos;
    nmis = mis;
    case (phase)
      PH_SEP: begin
        if (!(is_ws || is_semi)) begin
          name_go = 1'b1;
          npos = '0;
          nmis = 1'b0;
        end
      end
      PH_NAME: name_go = 1'b1;
      PH_SKIP, PH_VAL_OTHER: begin
        if (is_semi) begin
          phase_next = PH_SEP;
        end
      end
      PH_VAL_MATCH: begin
        if (is_semi) begin
          held_next = '0;
          semi_next = 1'b1;
          byte_pend_next = 1'b1;
          phase_next = PH_DONE;
        end else if (is_ws) begin
          if (held < CntW'(HELD_DEPTH)) begin
            ram_we = 1'b1;
            held_next = held + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end else begin
          rep_cnt_next = held;
          held_next = '0;
          byte_pend_next = 1'b1;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    if (name_go) begin
      pos_next = npos;
      mis_next = nmis;
      phase_next = PH_NAME;
      if (is_eq) begin
        // exact match needs a clean name of the configured length
        if (!nmis && (key_len != '0) && (key_len <= KEY_LEN_W'(KEY_BYTES))
            && (npos == key_len)) begin
          phase_next = PH_VAL_MATCH;
        end else begin
          phase_next = PH_VAL_OTHER;
        end
        held_next = '0;
      end else if (is_semi) begin
        phase_next = PH_SEP;
      end else if (is_ws) begin
        phase_next = PH_SKIP;
      end else begin
        if (npos < POS_W'(KEY_BYTES)) begin
          if (key_sel != b) begin
            mis_next = 1'b1;
          end
        end else begin
          mis_next = 1'b1;
        end
        if (npos != POS_MAX) begin
          pos_next = npos + 1'b1;
        end
      end
    end

    end_pend_next = in_data.header_end && (phase_next != PH_DONE);
    end_kind_next = (phase_next == PH_VAL_MATCH) ? KIND_END : KIND_NOT_FOUND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEP;
      pos <= '0;
      mis <= 1'b0;
      held <= '0;
      ovf <= 1'b0;
      byte_pend <= 1'b0;
      end_pend <= 1'b0;
      rep_cnt <= '0;
      rep_idx <= '0;
    end else if (cmd.accept) begin
      byte_pend <= byte_pend_next;
      end_pend <= end_pend_next;
      rep_cnt <= rep_cnt_next;
      rep_idx <= '0;
      if (in_data.header_end) begin
        phase <= PH_SEP;
        pos <= '0;
        mis <= 1'b0;
        held <= '0;
        ovf <= 1'b0;
      end else begin
        phase <= phase_next;
        pos <= pos_next;
        mis <= mis_next;
        held <= held_next;
        ovf <= ovf_next;
      end
    end else if (cmd.rep_step) begin
      rep_idx <= rep_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= b;
      semi_q <= semi_next;
      end_kind <= end_kind_next;
      ovf_q <= ovf_next;
    end
  end

  cve_ram #(
    .WIDTH(1),
    .DEPTH(HELD_DEPTH)
  ) u_held_ram (
    .clk  (clk),
    .we   (cmd.accept && ram_we),
    .waddr(held[AddrW-1:0]),
    .wdata(b == CHAR_TAB),
    .raddr(rep_idx[AddrW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    word.pending_overflow = ovf_q;
    word.last_of_run = cmd.last;
    word.value_byte = 8'h00;
    word.result_kind = KIND_VALUE;
    case (cmd.sel)
      SEL_REPLAY: begin
        word.value_byte = ram_rdata ? CHAR_TAB : CHAR_SPACE;
      end
      SEL_BYTE: begin
        if (semi_q) begin
          word.result_kind = KIND_END;
        end else begin
          word.value_byte = byte_q;
        end
      end
      SEL_FINAL: begin
        word.result_kind = end_kind;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= word;
    end
  end

  assign status.rep_more = (rep_idx < rep_cnt);
  assign status.byte_pend = byte_pend;
  assign status.end_pend = end_pend;
  assign status.out_free = !out_valid || out_ready;

endmodule
